@@ hdl/wavhp_pkg.sv @@
package wavhp_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORMAT_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DATA_BYTES   = 8'd1;

    localparam logic [7:0]  MAX_FORMAT_RESET = 8'd100;
    localparam logic [15:0] MIN_DATA_RESET   = 16'd1024;

    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;
    localparam logic [31:0] ID_DISP = 32'h5053_4944;
    localparam logic [31:0] ID_LIST = 32'h5453_494C;
    localparam logic [31:0] ID_FACT = 32'h7463_6166;

    localparam int unsigned OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [1:0]  channels;
        logic [4:0]  bits_per_sample;
        logic [15:0] sample_rate;
        logic [31:0] data_bytes;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

endpackage

@@ hdl/wavhp_in_stage.sv @@
module wavhp_in_stage
    import wavhp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hdl/wavhp_parser.sv @@
module wavhp_parser
    import wavhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_write i_cfg,
    input  logic       i_fire,
    input  t_in_item   i_item,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  r_max_fmt;
    logic [15:0] r_min_data;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_pos, n_pos;
    logic [31:0] r_id, n_id;
    logic [31:0] r_len, n_len;
    logic [31:0] r_rem, n_rem;
    logic        r_tag, n_tag;
    logic [1:0]  r_ch, n_ch;
    logic [4:0]  r_bits, n_bits;
    logic [15:0] r_rate, n_rate;

    logic        bad, good;
    logic [7:0]  b;
    logic [6:0]  pos_inc;
    logic [31:0] id_shift, len_shift, rem_dec, sz;

    assign b         = i_item.data_byte;
    assign pos_inc   = r_pos + 7'd1;
    assign id_shift  = {b, r_id[31:8]};
    assign len_shift = {b, r_len[31:8]};
    assign rem_dec   = r_rem - 32'd1;
    assign sz        = len_shift + {31'd0, len_shift[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fmt  <= MAX_FORMAT_RESET;
            r_min_data <= MIN_DATA_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_FORMAT_BYTES: r_max_fmt  <= i_cfg.data[7:0];
                CFG_MIN_DATA_BYTES:   r_min_data <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_id    = r_id;
        n_len   = r_len;
        n_rem   = r_rem;
        n_tag   = r_tag;
        n_ch    = r_ch;
        n_bits  = r_bits;
        n_rate  = r_rate;
        bad     = 1'b0;
        good    = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos >= 7'd8) begin
                    n_id = id_shift;
                end
                n_pos = pos_inc;
                if (pos_inc >= 7'd12) begin
                    if (n_id == ID_WAVE) begin
                        n_phase = PH_CHUNK;
                        n_pos   = '0;
                        n_id    = '0;
                        n_len   = '0;
                    end else begin
                        bad = 1'b1;
                    end
                end
            end
            PH_CHUNK: begin
                if (r_pos < 7'd4) begin
                    n_id = id_shift;
                end else begin
                    n_len = len_shift;
                end
                n_pos = pos_inc;
                if (r_pos == 7'd7) begin
                    if (r_id == ID_FMT) begin
                        if (sz > {24'd0, r_max_fmt} || sz < 32'd16) begin
                            bad = 1'b1;
                        end else begin
                            n_phase = PH_FMT;
                            n_pos   = '0;
                            n_rem   = sz;
                            n_tag   = 1'b0;
                        end
                    end else if (r_id == ID_DATA) begin
                        if (len_shift < {16'd0, r_min_data}) begin
                            bad = 1'b1;
                        end else begin
                            good = 1'b1;
                        end
                    end else if (r_id == ID_DISP || r_id == ID_LIST || r_id == ID_FACT) begin
                        if (sz == 32'd0) begin
                            n_pos = '0;
                            n_id  = '0;
                            n_len = '0;
                        end else begin
                            n_phase = PH_SKIP;
                            n_rem   = sz;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
            end
            PH_FMT: begin
                case (r_pos)
                    7'd0: n_tag = (b == 8'd1);
                    7'd2: begin
                        if (b == 8'd1 || b == 8'd2) begin
                            n_ch = b[1:0];
                        end else begin
                            n_tag = 1'b0;
                        end
                    end
                    7'd4: n_rate[7:0]  = b;
                    7'd5: n_rate[15:8] = b;
                    7'd14: begin
                        if (b == 8'd8 || b == 8'd16) begin
                            n_bits = b[4:0];
                        end else begin
                            n_tag = 1'b0;
                        end
                    end
                    default: ;
                endcase
                if (r_pos < 7'd127) begin
                    n_pos = pos_inc;
                end
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    if (n_tag) begin
                        n_phase = PH_CHUNK;
                        n_pos   = '0;
                        n_id    = '0;
                        n_len   = '0;
                    end else begin
                        bad = 1'b1;
                    end
                end
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_CHUNK;
                    n_pos   = '0;
                    n_id    = '0;
                    n_len   = '0;
                end
            end
            PH_DONE: ;
            default: ;
        endcase

        if (i_item.last_byte && !bad && !good && r_phase != PH_DONE) begin
            bad = 1'b1;
        end
        if (bad || good) begin
            n_phase = PH_DONE;
        end

        o_res_valid           = bad || good;
        o_res.status          = bad;
        o_res.channels        = bad ? 2'd0 : n_ch;
        o_res.bits_per_sample = bad ? 5'd0 : n_bits;
        o_res.sample_rate     = bad ? 16'd0 : n_rate;
        o_res.data_bytes      = bad ? 32'd0 : n_len;

        if (i_item.last_byte) begin
            n_phase = PH_HEADER;
            n_pos   = '0;
            n_id    = '0;
            n_len   = '0;
            n_rem   = '0;
            n_tag   = 1'b0;
            n_ch    = '0;
            n_bits  = '0;
            n_rate  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_tag   <= 1'b0;
            r_ch    <= '0;
            r_bits  <= '0;
            r_rate  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_id    <= n_id;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_tag   <= n_tag;
            r_ch    <= n_ch;
            r_bits  <= n_bits;
            r_rate  <= n_rate;
        end
    end

    a_result_ends_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && !i_item.last_byte |=> r_phase == PH_DONE)
        else $error("parse not closed after result");

    a_good_meets_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && !o_res.status |-> o_res.data_bytes >= {16'd0, r_min_data})
        else $error("accepted data chunk below minimum size");

endmodule

@@ hdl/wavhp_out_stage.sv @@
module wavhp_out_stage
    import wavhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.status |-> r_res.channels == 2'd0 && r_res.bits_per_sample == 5'd0
            && r_res.sample_rate == 16'd0 && r_res.data_bytes == 32'd0)
        else $error("error result carries nonzero fields");

endmodule

@@ hdl/wav_header_parser_unit.sv @@
// A byte waits in the input register; its parse result goes to m_axis via the result register.
// Throughput: one byte per cycle, sustained while m_axis_tready stays high.
// Input register and result register each decouple one side; the parse state updates per byte.
// Reset (i_rst_n low at a clock edge) clears parse state, both stages and sets
// max_format_bytes to 100 and min_data_bytes to 1024.
module wav_header_parser_unit
    import wavhp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  logic                         s_axis_tlast,   // last_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // [1:0] channels, [6:2] bits_per_sample,
                                                         // [22:7] sample_rate, [54:23] data_bytes
    output logic                         m_axis_tuser,   // status
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_in_item   in_item, stage_item;
    logic       stage_valid, advance, out_can_load, res_valid;
    t_result    res, out_res;
    t_cfg_write cfg;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;
    assign o_cfg_ready       = 1'b1;
    assign cfg.valid         = i_cfg_valid;
    assign cfg.index         = i_cfg_index;
    assign cfg.data          = i_cfg_data;
    assign advance           = stage_valid && out_can_load;

    wavhp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    wavhp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (advance),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wavhp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && res_valid),
        .i_res      (res),
        .o_can_load (out_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res)
    );

    assign m_axis_tuser = out_res.status;
    assign m_axis_tdata = {1'b0, out_res.data_bytes, out_res.sample_rate,
                           out_res.bits_per_sample, out_res.channels};

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && stage_valid |-> !s_axis_tready)
        else $error("input taken while both stages are held");

endmodule
